[rtl/qytt_pkg.sv]
// ----------------------------------------------------------------------------
// qytt_pkg: shared types and constants of the quaternion yaw turn tracker
// Angle scaling, CORDIC arctangent table, controller commands and states.
// ----------------------------------------------------------------------------
`default_nettype none

package qytt_pkg;

    // angle scaling
    localparam int ANGLE_FRAC_BITS  = 12;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FINE_BITS        = 30;
    localparam int ATAN_IDX_W       = 5;
    localparam int DROP_BITS        = FINE_BITS - ANGLE_FRAC_BITS;

    // field and datapath widths
    localparam int QW      = 16;
    localparam int PROD_W  = 2 * QW;
    localparam int XY_W    = PROD_W + 3;
    localparam int ANG_W   = FINE_BITS + 5;
    localparam int YAW_W   = ANGLE_FRAC_BITS + 3;
    localparam int DIFF_W  = YAW_W + 1;
    localparam int TOT_W   = 16;
    localparam int LIMIT_W = YAW_W;
    localparam int RATE_W  = 12;
    localparam int DRIVE_W = RATE_W + 1;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    // pi and 2pi in 2^-30 rad and in output angle units
    localparam longint PI_FINE_L     = 64'sd3373259426;
    localparam longint TWO_PI_FINE_L = 64'sd6746518853;
    localparam longint HALF_L        = 64'sd1 <<< (DROP_BITS - 1);
    localparam longint PI_Q_L        = (PI_FINE_L + HALF_L) >>> DROP_BITS;
    localparam longint TWO_PI_Q_L    = (TWO_PI_FINE_L + HALF_L) >>> DROP_BITS;

    localparam ang_t  PI_FINE      = ang_t'(PI_FINE_L);
    localparam ang_t  TWO_PI_FINE  = ang_t'(TWO_PI_FINE_L);
    localparam ang_t  ROUND_HALF   = ang_t'(HALF_L);
    localparam ang_t  TWO_PI_Q_ANG = ang_t'(TWO_PI_Q_L);
    localparam diff_t PI_Q         = diff_t'(PI_Q_L);
    localparam diff_t NEG_PI_Q     = diff_t'(-PI_Q_L);
    localparam diff_t TWO_PI_Q     = diff_t'(TWO_PI_Q_L);

    // register map, byte address 4*index
    typedef enum logic [2:0] {
        REG_START_Z    = 3'd0,
        REG_START_W    = 3'd1,
        REG_END_Z      = 3'd2,
        REG_END_W      = 3'd3,
        REG_JUMP_LIMIT = 3'd4,
        REG_TURN_RATE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [QW-1:0] start_z;
        logic signed [QW-1:0] start_w;
        logic signed [QW-1:0] end_z;
        logic signed [QW-1:0] end_w;
        logic [LIMIT_W-1:0]   jump_limit;
        logic [RATE_W-1:0]    turn_rate;
    } cfg_t;

    // which orientation the shared CORDIC works on
    typedef enum logic [1:0] {
        SRC_SAMPLE = 2'd0,
        SRC_END    = 2'd1,
        SRC_START  = 2'd2
    } src_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_ITER,
        ST_FIX1,
        ST_FIX2,
        ST_STORE,
        ST_ACC,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        src_sel_t src;
        logic     in_load;
        logic     mul_en;
        logic     init_en;
        logic     iter_en;
        logic     fix1_en;
        logic     fix2_en;
        logic     end_en;
        logic     target_en;
        logic     step_en;
        logic     acc_en;
        logic     commit_en;
    } cmd_t;

    typedef struct packed {
        logic iter_last;
    } stat_t;

    // atan(2^-i) in 2^-30 rad, truncated
    function automatic ang_t atan_fine(input logic [ATAN_IDX_W-1:0] idx);
        ang_t v;
        unique case (idx)
            5'd0:    v = ang_t'(64'h3243F6A8);
            5'd1:    v = ang_t'(64'h1DAC6705);
            5'd2:    v = ang_t'(64'h0FADBAFC);
            5'd3:    v = ang_t'(64'h07F56EA6);
            5'd4:    v = ang_t'(64'h03FEAB76);
            5'd5:    v = ang_t'(64'h01FFD55B);
            5'd6:    v = ang_t'(64'h00FFFAAA);
            5'd7:    v = ang_t'(64'h007FFF55);
            5'd8:    v = ang_t'(64'h003FFFEA);
            5'd9:    v = ang_t'(64'h001FFFFD);
            5'd10:   v = ang_t'(64'h000FFFFF);
            5'd11:   v = ang_t'(64'h0007FFFF);
            5'd12:   v = ang_t'(64'h0003FFFF);
            5'd13:   v = ang_t'(64'h0001FFFF);
            5'd14:   v = ang_t'(64'h0000FFFF);
            5'd15:   v = ang_t'(64'h00007FFF);
            5'd16:   v = ang_t'(64'h00003FFF);
            5'd17:   v = ang_t'(64'h00001FFF);
            5'd18:   v = ang_t'(64'h00000FFF);
            5'd19:   v = ang_t'(64'h000007FF);
            5'd20:   v = ang_t'(64'h000003FF);
            5'd21:   v = ang_t'(64'h000001FF);
            5'd22:   v = ang_t'(64'h000000FF);
            5'd23:   v = ang_t'(64'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/qytt_ctrl.sv]
// ----------------------------------------------------------------------------
// qytt_ctrl: sequencer of the yaw turn tracker
// Runs the shared CORDIC over goal and sample orientations and hands results out.
// ----------------------------------------------------------------------------
`default_nettype none

module qytt_ctrl import qytt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  logic  goal_write,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    src_sel_t    src_reg, src_next;
    logic        tgt_ok_reg, tgt_ok_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            src_reg     <= SRC_SAMPLE;
            tgt_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_reg     <= src_next;
            tgt_ok_reg  <= tgt_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        src_next     = src_reg;
        tgt_ok_next  = tgt_ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.src      = src_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    // goal yaws are recomputed only after reset or a goal write
                    src_next    = tgt_ok_reg ? SRC_SAMPLE : SRC_END;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init_en = 1'b1;
                state_next  = ST_ITER;
            end
            ST_ITER: begin
                cmd.iter_en = 1'b1;
                if (stat.iter_last) begin
                    state_next = ST_FIX1;
                end
            end
            ST_FIX1: begin
                cmd.fix1_en = 1'b1;
                state_next  = ST_FIX2;
            end
            ST_FIX2: begin
                cmd.fix2_en = 1'b1;
                state_next  = ST_STORE;
            end
            ST_STORE: begin
                unique case (src_reg)
                    SRC_END: begin
                        cmd.end_en = 1'b1;
                        src_next   = SRC_START;
                        state_next = ST_MUL;
                    end
                    SRC_START: begin
                        cmd.target_en = 1'b1;
                        tgt_ok_next   = 1'b1;
                        src_next      = SRC_SAMPLE;
                        state_next    = ST_MUL;
                    end
                    SRC_SAMPLE: begin
                        cmd.step_en = 1'b1;
                        state_next  = ST_ACC;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit_en = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (goal_write) begin
            tgt_ok_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/qytt_dp.sv]
// ----------------------------------------------------------------------------
// qytt_dp: datapath of the yaw turn tracker
// Shared vectoring CORDIC, angle wrap and rounding, turn accumulator, outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module qytt_dp import qytt_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic signed [QW-1:0]       s_sample_z,
    input  logic signed [QW-1:0]       s_sample_w,
    input  logic                       s_restart,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    output logic [YAW_W-1:0]           m_yaw_now,
    output logic signed [TOT_W-1:0]    m_turned_angle,
    output logic signed [YAW_W-1:0]    m_target_turn,
    output logic signed [DRIVE_W-1:0]  m_drive_command,
    output logic                       m_turn_done
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [TOT_W:0]   sum_t;

    // latched sample
    logic signed [QW-1:0]     in_z_reg, in_w_reg;
    logic                     restart_reg;
    logic signed [QW-1:0]     op_z, op_w;

    // products and cordic state
    logic signed [PROD_W-1:0] ww_reg, zz_reg, wz_reg;
    xy_t                      x0, y0, x_init, y_init;
    ang_t                     ang_init;
    xy_t                      x_reg, y_reg, x_next, y_next, dx, dy;
    ang_t                     ang_reg, ang_next, step_ang;
    logic                     zero_reg;
    logic [CNT_W-1:0]         cnt_reg;

    // angle wrap and rounding
    ang_t                     wrap_a, wrap_next, wrap_reg, rnd, rnd_fix;
    logic [YAW_W-1:0]         yaw_reg, end_yaw_reg, prev_yaw_reg;

    // goal difference
    diff_t                    t_raw, t_wrap, t_neg;
    logic signed [YAW_W-1:0]  target_reg;
    logic [YAW_W-1:0]         abs_t_reg;

    // turn accumulator
    diff_t                    d_fwd, d_rev, d_mag;
    diff_t                    diff_reg;
    logic                     diff_ok_reg;
    logic signed [TOT_W-1:0]  total_reg, cand_reg, cand_next, base_tot;
    sum_t                     sum, abs_a;
    logic                     done_c;
    logic signed [DRIVE_W-1:0] rate_s, drive_c;

    // output register
    logic [YAW_W-1:0]          out_yaw_reg;
    logic signed [TOT_W-1:0]   out_tot_reg;
    logic signed [YAW_W-1:0]   out_tgt_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;
    logic                      out_done_reg;

    always_comb begin
        unique case (cmd.src)
            SRC_END: begin
                op_z = cfg.end_z;
                op_w = cfg.end_w;
            end
            SRC_START: begin
                op_z = cfg.start_z;
                op_w = cfg.start_w;
            end
            SRC_SAMPLE: begin
                op_z = in_z_reg;
                op_w = in_w_reg;
            end
            default: begin
                op_z = in_z_reg;
                op_w = in_w_reg;
            end
        endcase
    end

    // x = w^2 - z^2, y = 2wz, left half plane folded by pi
    always_comb begin
        x0 = xy_t'(ww_reg) - xy_t'(zz_reg);
        y0 = xy_t'(wz_reg) <<< 1;
        if (x0 < 0) begin
            x_init   = -x0;
            y_init   = -y0;
            ang_init = (y0 >= 0) ? PI_FINE : -PI_FINE;
        end else begin
            x_init   = x0;
            y_init   = y0;
            ang_init = '0;
        end
    end

    // one micro-rotation
    always_comb begin
        dx       = y_reg >>> cnt_reg;
        dy       = x_reg >>> cnt_reg;
        step_ang = atan_fine(ATAN_IDX_W'(cnt_reg));
        if (y_reg > 0) begin
            x_next   = x_reg + dx;
            y_next   = y_reg - dy;
            ang_next = ang_reg + step_ang;
        end else begin
            x_next   = x_reg - dx;
            y_next   = y_reg + dy;
            ang_next = ang_reg - step_ang;
        end
    end

    assign stat.iter_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    // wrap to [0, 2pi) then round half up to output units
    always_comb begin
        wrap_a    = (ang_reg < 0) ? ang_reg + TWO_PI_FINE : ang_reg;
        wrap_next = (wrap_a < 0) ? '0 : wrap_a;
        rnd       = (wrap_reg + ROUND_HALF) >>> DROP_BITS;
        rnd_fix   = (rnd >= TWO_PI_Q_ANG) ? rnd - TWO_PI_Q_ANG : rnd;
    end

    // target = end - start, wrapped to [-pi, pi]
    always_comb begin
        t_raw = $signed({1'b0, end_yaw_reg}) - $signed({1'b0, yaw_reg});
        if (t_raw > PI_Q) begin
            t_wrap = t_raw - TWO_PI_Q;
        end else if (t_raw < NEG_PI_Q) begin
            t_wrap = t_raw + TWO_PI_Q;
        end else begin
            t_wrap = t_raw;
        end
        t_neg = -t_wrap;
    end

    // raw step, no wrap handling across 0/2pi
    always_comb begin
        d_fwd = $signed({1'b0, yaw_reg}) - $signed({1'b0, prev_yaw_reg});
        d_rev = $signed({1'b0, prev_yaw_reg}) - $signed({1'b0, yaw_reg});
        d_mag = d_fwd[DIFF_W-1] ? d_rev : d_fwd;
    end

    // saturating accumulate
    always_comb begin
        base_tot = restart_reg ? '0 : total_reg;
        sum      = sum_t'(base_tot) + (diff_ok_reg ? sum_t'(diff_reg) : sum_t'(0));
        if (sum[TOT_W] != sum[TOT_W-1]) begin
            cand_next = sum[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
        end else begin
            cand_next = sum[TOT_W-1:0];
        end
    end

    always_comb begin
        abs_a   = (cand_reg < 0) ? -sum_t'(cand_reg) : sum_t'(cand_reg);
        done_c  = abs_a >= sum_t'({1'b0, abs_t_reg});
        rate_s  = $signed({1'b0, cfg.turn_rate});
        if (done_c) begin
            drive_c = '0;
        end else begin
            drive_c = target_reg[YAW_W-1] ? -rate_s : rate_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_z_reg    <= s_sample_z;
            in_w_reg    <= s_sample_w;
            restart_reg <= s_restart;
        end
        if (cmd.mul_en) begin
            ww_reg <= op_w * op_w;
            zz_reg <= op_z * op_z;
            wz_reg <= op_w * op_z;
        end
        if (cmd.init_en) begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            ang_reg  <= ang_init;
            zero_reg <= (x0 == '0) && (y0 == '0);
            cnt_reg  <= '0;
        end
        if (cmd.iter_en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.fix1_en) begin
            wrap_reg <= wrap_next;
        end
        if (cmd.fix2_en) begin
            yaw_reg <= zero_reg ? '0 : rnd_fix[YAW_W-1:0];
        end
        if (cmd.end_en) begin
            end_yaw_reg <= yaw_reg;
        end
        if (cmd.target_en) begin
            target_reg <= t_wrap[YAW_W-1:0];
            abs_t_reg  <= t_wrap[DIFF_W-1] ? t_neg[YAW_W-1:0] : t_wrap[YAW_W-1:0];
        end
        if (cmd.step_en) begin
            diff_reg    <= restart_reg ? '0 : d_fwd;
            diff_ok_reg <= d_mag <= $signed({1'b0, cfg.jump_limit});
        end
        if (cmd.acc_en) begin
            cand_reg <= cand_next;
        end
        if (cmd.commit_en) begin
            out_yaw_reg   <= yaw_reg;
            out_tot_reg   <= cand_reg;
            out_tgt_reg   <= target_reg;
            out_drive_reg <= drive_c;
            out_done_reg  <= done_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_yaw_reg <= '0;
            total_reg    <= '0;
        end else if (cmd.commit_en) begin
            prev_yaw_reg <= yaw_reg;
            total_reg    <= cand_reg;
        end
    end

    assign m_yaw_now       = out_yaw_reg;
    assign m_turned_angle  = out_tot_reg;
    assign m_target_turn   = out_tgt_reg;
    assign m_drive_command = out_drive_reg;
    assign m_turn_done     = out_done_reg;

endmodule

`default_nettype wire

[rtl/quaternion_yaw_turn_tracker.sv]
// ----------------------------------------------------------------------------
// quaternion_yaw_turn_tracker: odometry yaw, turned angle and turn drive
// an accepted request runs MUL, INIT, the ITER steps, FIX1, FIX2, STORE, ACC and FINISH before m_valid
// a new request is taken only back in IDLE, once the shared CORDIC is done and the result is committed
// after reset or a goal register write the next request first runs the CORDIC for the end and start goals
// reset: aresetn low clears previous yaw, turned angle and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_yaw_turn_tracker import qytt_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // sample request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [QW-1:0]       s_sample_z,
    input  logic signed [QW-1:0]       s_sample_w,
    input  logic                       s_restart,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [YAW_W-1:0]           m_yaw_now,
    output logic signed [TOT_W-1:0]    m_turned_angle,
    output logic signed [YAW_W-1:0]    m_target_turn,
    output logic signed [DRIVE_W-1:0]  m_drive_command,
    output logic                       m_turn_done,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    // goal orientations and limits; the user writes them only while idle, the block does not enforce it
    logic signed [QW-1:0] start_z_reg, start_w_reg, end_z_reg, end_w_reg;
    logic [LIMIT_W-1:0]   jump_limit_reg;
    logic [RATE_W-1:0]    turn_rate_reg;

    reg_idx_t reg_idx;
    logic     wr_en;
    logic     goal_write;
    cfg_t     cfg;
    cmd_t     cmd;
    stat_t    stat;

    // registers sit at byte address 4*index, writes complete in the access phase
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_z_reg    <= '0;
            start_w_reg    <= QW'(16384);
            end_z_reg      <= '0;
            end_w_reg      <= QW'(16384);
            jump_limit_reg <= LIMIT_W'(4096);
            turn_rate_reg  <= RATE_W'(1229);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_Z:    start_z_reg    <= pwdata[QW-1:0];
                REG_START_W:    start_w_reg    <= pwdata[QW-1:0];
                REG_END_Z:      end_z_reg      <= pwdata[QW-1:0];
                REG_END_W:      end_w_reg      <= pwdata[QW-1:0];
                REG_JUMP_LIMIT: jump_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_TURN_RATE:  turn_rate_reg  <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // readback, signed goal components sign-extended
    always_comb begin
        unique case (reg_idx)
            REG_START_Z:    prdata = DATA_W'(start_z_reg);
            REG_START_W:    prdata = DATA_W'(start_w_reg);
            REG_END_Z:      prdata = DATA_W'(end_z_reg);
            REG_END_W:      prdata = DATA_W'(end_w_reg);
            REG_JUMP_LIMIT: prdata = DATA_W'(jump_limit_reg);
            REG_TURN_RATE:  prdata = DATA_W'(turn_rate_reg);
            default:        prdata = '0;
        endcase
    end

    // any goal write invalidates the cached target turn
    assign goal_write = wr_en && ((reg_idx == REG_START_Z) || (reg_idx == REG_START_W) ||
                                  (reg_idx == REG_END_Z)   || (reg_idx == REG_END_W));

    assign cfg.start_z    = start_z_reg;
    assign cfg.start_w    = start_w_reg;
    assign cfg.end_z      = end_z_reg;
    assign cfg.end_w      = end_w_reg;
    assign cfg.jump_limit = jump_limit_reg;
    assign cfg.turn_rate  = turn_rate_reg;

    // sequencer: runs the CORDIC for end goal and start goal when they are stale, then the sample
    qytt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .goal_write (goal_write),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: shared CORDIC, accumulator and result register
    qytt_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_sample_z      (s_sample_z),
        .s_sample_w      (s_sample_w),
        .s_restart       (s_restart),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .m_yaw_now       (m_yaw_now),
        .m_turned_angle  (m_turned_angle),
        .m_target_turn   (m_target_turn),
        .m_drive_command (m_drive_command),
        .m_turn_done     (m_turn_done)
    );

`ifndef SYNTHESIS
    // the CORDIC is busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the CORDIC is busy");

    // no drive once the turn is reached
    a_done_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_turn_done |-> m_drive_command == '0)
        else $error("drive command nonzero after turn done");

    // a zero target turn is reached at once
    a_zero_target_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_target_turn == '0) |-> m_turn_done)
        else $error("zero target turn not flagged done");

    // yaw stays below 2pi
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_yaw_now} < TWO_PI_Q)
        else $error("yaw out of range");
`endif

endmodule

`default_nettype wire
